### rtl/gdad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdad_pkg
// Shared types, constants and calendar functions for the date adder.
// ----------------------------------------------------------------------------
package gdad_pkg;

    localparam int DAYS_WIDTH      = 16;
    localparam int YEAR_W          = 14;
    localparam int MONTH_W         = 4;
    localparam int DAY_W           = 5;
    // day + full year + day count stays below 2^(DAYS_WIDTH+2) for any DAYS_WIDTH >= 8
    localparam int REMAIN_W        = DAYS_WIDTH + 2;
    localparam int YLEN_W          = 9;

    localparam int LEAP_CYCLE      = 400;
    localparam int REDUCE_STEPS    = 6;     // 400 << 5 is the largest multiple tried
    localparam int STEP_W          = 3;

    localparam logic [MONTH_W-1:0] MONTH_JAN       = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = MONTH_W'(12);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_PRESUM,
        ST_YEARS,
        ST_MONTHS,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic reduce;
        logic presum;
        logic walk_init;
        logic year_step;
        logic month_step;
    } cmd_t;

    typedef struct packed {
        logic reduce_last;
        logic presum_done;
        logic year_fits;
        logic month_fits;
    } status_t;

    // Length of a month; zero for codes outside January..December.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        begin
            unique case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
                4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
                4'd2:                                       len = leap ? DAY_W'(29)
                                                                       : DAY_W'(28);
                default:                                    len = '0;
            endcase
            return len;
        end
    endfunction

    function automatic logic [YLEN_W-1:0] year_len(input logic leap);
        return leap ? YLEN_W'(366) : YLEN_W'(365);
    endfunction

endpackage

### rtl/gdad_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdad_ctrl
// Sequencer: year reduction, month presum, year walk, month walk, result.
// ----------------------------------------------------------------------------
module gdad_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  gdad_pkg::status_t status,
    output gdad_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done
);

    gdad_pkg::state_t state_reg;
    gdad_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gdad_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        done       = 1'b0;
        busy       = (state_reg != gdad_pkg::ST_IDLE);
        unique case (state_reg)
            gdad_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = gdad_pkg::ST_REDUCE;
                end
            end
            gdad_pkg::ST_REDUCE:
            begin
                cmd.reduce = 1'b1;
                if (status.reduce_last)
                begin
                    state_next = gdad_pkg::ST_PRESUM;
                end
            end
            gdad_pkg::ST_PRESUM:
            begin
                if (status.presum_done)
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = gdad_pkg::ST_YEARS;
                end
                else
                begin
                    cmd.presum = 1'b1;
                end
            end
            gdad_pkg::ST_YEARS:
            begin
                if (status.year_fits)
                begin
                    state_next = gdad_pkg::ST_MONTHS;
                end
                else
                begin
                    cmd.year_step = 1'b1;
                end
            end
            gdad_pkg::ST_MONTHS:
            begin
                if (status.month_fits)
                begin
                    state_next = gdad_pkg::ST_DONE;
                end
                else
                begin
                    cmd.month_step = 1'b1;
                end
            end
            gdad_pkg::ST_DONE:
            begin
                done       = 1'b1;
                state_next = gdad_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = gdad_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/gdad_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdad_datapath
// Year, year-mod-400, month and remaining-day registers with step logic.
// ----------------------------------------------------------------------------
module gdad_datapath (
    input  logic                                clk,
    input  gdad_pkg::cmd_t                      cmd,
    input  logic [gdad_pkg::YEAR_W-1:0]         start_year,
    input  logic [gdad_pkg::MONTH_W-1:0]        start_month,
    input  logic [gdad_pkg::DAY_W-1:0]          start_day,
    input  logic [gdad_pkg::DAYS_WIDTH-1:0]     days_to_add,
    output gdad_pkg::status_t                   status,
    output logic [gdad_pkg::YEAR_W-1:0]         end_year,
    output logic [gdad_pkg::MONTH_W-1:0]        end_month,
    output logic [gdad_pkg::DAY_W-1:0]          end_day
);

    localparam int YW = gdad_pkg::YEAR_W;
    localparam int MW = gdad_pkg::MONTH_W;
    localparam int RW = gdad_pkg::REMAIN_W;
    localparam int SW = gdad_pkg::STEP_W;

    logic [YW-1:0] year_reg;
    logic [YW-1:0] year_next;
    logic [YW-1:0] mod_reg;        // year mod 400 once reduction is over
    logic [YW-1:0] mod_next;
    logic [MW-1:0] month_reg;
    logic [MW-1:0] m_reg;
    logic [MW-1:0] m_next;
    logic [RW-1:0] remain_reg;
    logic [RW-1:0] remain_next;
    logic [SW-1:0] step_reg;
    logic [SW-1:0] step_next;

    logic                                leap;
    logic [gdad_pkg::DAY_W-1:0]          mlen;
    logic [gdad_pkg::YLEN_W-1:0]         ylen;
    logic [YW-1:0]                       divisor;
    logic [YW-1:0]                       year_inc;
    logic [YW-1:0]                       mod_inc;

    // Divisible by 4, and not a century unless divisible by 400.
    assign leap = (year_reg[1:0] == 2'b00) &&
                  (mod_reg != YW'(100)) && (mod_reg != YW'(200)) && (mod_reg != YW'(300));
    assign mlen = gdad_pkg::month_len(m_reg, leap);
    assign ylen = gdad_pkg::year_len(leap);

    assign divisor = YW'(gdad_pkg::LEAP_CYCLE) << step_reg;

    // Year wraps modulo 2^14, which restarts the 400-year count.
    assign year_inc = year_reg + YW'(1);
    assign mod_inc  = (year_reg == {YW{1'b1}}) ? '0 :
                      (mod_reg == YW'(gdad_pkg::LEAP_CYCLE - 1)) ? '0 : mod_reg + YW'(1);

    assign status.reduce_last = (step_reg == '0);
    assign status.presum_done = (m_reg >= month_reg) || (m_reg > gdad_pkg::MONTHS_PER_YEAR);
    assign status.year_fits   = (remain_reg <= RW'(ylen));
    assign status.month_fits  = (remain_reg <= RW'(mlen));

    always_comb
    begin
        year_next   = year_reg;
        mod_next    = mod_reg;
        m_next      = m_reg;
        remain_next = remain_reg;
        step_next   = step_reg;
        priority if (cmd.load)
        begin
            year_next   = start_year;
            mod_next    = start_year;
            m_next      = gdad_pkg::MONTH_JAN;
            remain_next = RW'(start_day) + RW'(days_to_add);
            step_next   = SW'(gdad_pkg::REDUCE_STEPS - 1);
        end
        else if (cmd.reduce)
        begin
            if (mod_reg >= divisor)
            begin
                mod_next = mod_reg - divisor;
            end
            step_next = step_reg - SW'(1);
        end
        else if (cmd.presum)
        begin
            remain_next = remain_reg + RW'(mlen);
            m_next      = m_reg + MW'(1);
        end
        else if (cmd.walk_init)
        begin
            m_next = gdad_pkg::MONTH_JAN;
        end
        else if (cmd.year_step)
        begin
            remain_next = remain_reg - RW'(ylen);
            year_next   = year_inc;
            mod_next    = mod_inc;
        end
        else if (cmd.month_step)
        begin
            remain_next = remain_reg - RW'(mlen);
            if (m_reg >= gdad_pkg::MONTHS_PER_YEAR)
            begin
                m_next    = gdad_pkg::MONTH_JAN;
                year_next = year_inc;
                mod_next  = mod_inc;
            end
            else
            begin
                m_next = m_reg + MW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg   <= year_next;
        mod_reg    <= mod_next;
        m_reg      <= m_next;
        remain_reg <= remain_next;
        step_reg   <= step_next;
        if (cmd.load)
        begin
            month_reg <= start_month;
        end
    end

    assign end_year  = year_reg;
    assign end_month = m_reg;
    assign end_day   = remain_reg[gdad_pkg::DAY_W-1:0];

endmodule

### rtl/gregorian_date_add_days_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_add_days_core
// Adds a day count to a Gregorian date and returns the resulting date.
// ----------------------------------------------------------------------------
// Usage:
//   Drive start_year/start_month/start_day/days_to_add and raise start while
//   busy is low; the transaction is taken at that clock edge and busy rises.
//   The result appears on end_year/end_month/end_day, marked by done for exactly
//   one cycle; the receiver has no way to hold it off, so capture it then.
//   busy falls in the cycle after done.
// Sequence after the accepting edge, done in the last state:
//   year mod 400 reduction, one restoring step a cycle; a presum step per
//   month before start_month; walk setup; a year step per whole year skipped
//   and a check; a month step per month walked and a check; the result state.
//   One transaction at a time.
// Reset:
//   rst_n clears the sequencer to idle; any transaction in flight is dropped.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    output logic                                done,
    input  logic [gdad_pkg::YEAR_W-1:0]         start_year,
    input  logic [gdad_pkg::MONTH_W-1:0]        start_month,
    input  logic [gdad_pkg::DAY_W-1:0]          start_day,
    input  logic [gdad_pkg::DAYS_WIDTH-1:0]     days_to_add,
    output logic [gdad_pkg::YEAR_W-1:0]         end_year,
    output logic [gdad_pkg::MONTH_W-1:0]        end_month,
    output logic [gdad_pkg::DAY_W-1:0]          end_day
);

    gdad_pkg::cmd_t    cmd;
    gdad_pkg::status_t status;

    gdad_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    gdad_datapath u_datapath (
        .clk         (clk),
        .cmd         (cmd),
        .start_year  (start_year),
        .start_month (start_month),
        .start_day   (start_day),
        .days_to_add (days_to_add),
        .status      (status),
        .end_year    (end_year),
        .end_month   (end_month),
        .end_day     (end_day)
    );

endmodule
